### sv/vfq_pkg.sv
// Shared types, constants and corner tables for the voxel face quad emitter.
package vfq_pkg;

    localparam logic [2:0] DIR_TOP    = 3'd0;
    localparam logic [2:0] DIR_BOTTOM = 3'd1;
    localparam logic [2:0] DIR_RIGHT  = 3'd2;
    localparam logic [2:0] DIR_LEFT   = 3'd3;
    localparam logic [2:0] DIR_FRONT  = 3'd4;
    localparam logic [2:0] DIR_BACK   = 3'd5;
    localparam logic [2:0] NUM_DIRS   = 3'd6;

    localparam logic [2:0] LAST_VERT  = 3'd5;

    localparam logic OP_FACE = 1'b0;
    localparam logic OP_CUBE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OFF_NONE,
        OFF_ONE,
        OFF_W,
        OFF_H
    } vfq_off_t;

    typedef struct packed {
        vfq_off_t x;
        vfq_off_t y;
        vfq_off_t z;
    } vfq_corner_t;

    typedef struct packed {
        logic       cube;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pos_z;
        logic [2:0] dir;
        logic [7:0] voxel;
        logic [7:0] w;
        logic [7:0] h;
    } vfq_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } vfq_qstat_t;

    // corner index for each of the six emitted vertices: 0 1 2 2 3 0
    function automatic logic [1:0] emit_corner(input logic [2:0] k);
        logic [1:0] c;
        case (k)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd2;
            3'd4:    c = 2'd3;
            3'd5:    c = 2'd0;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic vfq_corner_t corner_offsets(input logic [2:0] dir,
                                                   input logic [1:0] corner);
        vfq_corner_t r;
        case ({dir, corner})
            {DIR_TOP, 2'd0}:    r = '{OFF_NONE, OFF_ONE,  OFF_NONE};
            {DIR_TOP, 2'd1}:    r = '{OFF_NONE, OFF_ONE,  OFF_W};
            {DIR_TOP, 2'd2}:    r = '{OFF_H,    OFF_ONE,  OFF_W};
            {DIR_TOP, 2'd3}:    r = '{OFF_H,    OFF_ONE,  OFF_NONE};
            {DIR_BOTTOM, 2'd0}: r = '{OFF_H,    OFF_NONE, OFF_NONE};
            {DIR_BOTTOM, 2'd1}: r = '{OFF_H,    OFF_NONE, OFF_W};
            {DIR_BOTTOM, 2'd2}: r = '{OFF_NONE, OFF_NONE, OFF_W};
            {DIR_BOTTOM, 2'd3}: r = '{OFF_NONE, OFF_NONE, OFF_NONE};
            {DIR_RIGHT, 2'd0}:  r = '{OFF_ONE,  OFF_W,    OFF_H};
            {DIR_RIGHT, 2'd1}:  r = '{OFF_ONE,  OFF_NONE, OFF_H};
            {DIR_RIGHT, 2'd2}:  r = '{OFF_ONE,  OFF_NONE, OFF_NONE};
            {DIR_RIGHT, 2'd3}:  r = '{OFF_ONE,  OFF_W,    OFF_NONE};
            {DIR_LEFT, 2'd0}:   r = '{OFF_NONE, OFF_W,    OFF_NONE};
            {DIR_LEFT, 2'd1}:   r = '{OFF_NONE, OFF_NONE, OFF_NONE};
            {DIR_LEFT, 2'd2}:   r = '{OFF_NONE, OFF_NONE, OFF_H};
            {DIR_LEFT, 2'd3}:   r = '{OFF_NONE, OFF_W,    OFF_H};
            {DIR_FRONT, 2'd0}:  r = '{OFF_NONE, OFF_H,    OFF_ONE};
            {DIR_FRONT, 2'd1}:  r = '{OFF_NONE, OFF_NONE, OFF_ONE};
            {DIR_FRONT, 2'd2}:  r = '{OFF_W,    OFF_NONE, OFF_ONE};
            {DIR_FRONT, 2'd3}:  r = '{OFF_W,    OFF_H,    OFF_ONE};
            {DIR_BACK, 2'd0}:   r = '{OFF_W,    OFF_H,    OFF_NONE};
            {DIR_BACK, 2'd1}:   r = '{OFF_W,    OFF_NONE, OFF_NONE};
            {DIR_BACK, 2'd2}:   r = '{OFF_NONE, OFF_NONE, OFF_NONE};
            {DIR_BACK, 2'd3}:   r = '{OFF_NONE, OFF_H,    OFF_NONE};
            default:            r = '{OFF_NONE, OFF_NONE, OFF_NONE};
        endcase
        return r;
    endfunction

    // coordinate plus selected offset, wrapping modulo 256
    function automatic logic [7:0] add_off(input logic [7:0] pos,
                                           input vfq_off_t code,
                                           input logic [7:0] w,
                                           input logic [7:0] h);
        logic [7:0] off;
        case (code)
            OFF_ONE: off = 8'd1;
            OFF_W:   off = w;
            OFF_H:   off = h;
            default: off = 8'd0;
        endcase
        return pos + off;
    endfunction

endpackage

### sv/vfq_front.sv
// Front end: takes requests, drops faces with no valid direction, feeds the queue.
module vfq_front
    import vfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       opcode,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] pos_z,
    input  logic [2:0] direction,
    input  logic [7:0] voxel_id,
    input  logic [7:0] width,
    input  logic [7:0] height,
    input  vfq_qstat_t qstat,
    output logic       busy,
    output logic       push,
    output vfq_item_t  push_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    vfq_item_t stage_reg;
    logic      accept;
    logic      keep;

    assign busy      = stage_valid_reg && qstat.full;
    assign push      = stage_valid_reg && !qstat.full;
    assign push_item = stage_reg;
    assign accept    = start && !busy;
    assign keep      = (opcode == OP_CUBE) || (direction < NUM_DIRS);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = keep;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.cube  <= opcode;
            stage_reg.pos_x <= pos_x;
            stage_reg.pos_y <= pos_y;
            stage_reg.pos_z <= pos_z;
            stage_reg.dir   <= direction;
            stage_reg.voxel <= voxel_id;
            stage_reg.w     <= width;
            stage_reg.h     <= height;
        end
    end

endmodule

### sv/vfq_queue.sv
// Short first-word-fall-through queue between front and back ends.
module vfq_queue
    import vfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vfq_item_t  push_item,
    input  logic       pop,
    output vfq_item_t  head,
    output vfq_qstat_t qstat
);

    vfq_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.valid = (count_reg != '0);
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/vfq_back.sv
// Back end: steps through faces and vertices of a job, one vertex per cycle.
module vfq_back
    import vfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vfq_item_t  head,
    input  vfq_qstat_t qstat,
    output logic       pop,
    output logic       vert_strobe,
    output logic [7:0] vert_x,
    output logic [7:0] vert_y,
    output logic [7:0] vert_z,
    output logic [7:0] vert_voxel,
    output logic [2:0] vert_face,
    output logic       last_vertex
);

    vfq_item_t   cur_reg;
    logic        active_reg;
    logic [2:0]  face_reg;
    logic [2:0]  k_reg;
    logic        strobe_reg;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic [7:0]  z_reg;
    logic [7:0]  voxel_reg;
    logic [2:0]  face_out_reg;
    logic        last_reg;

    logic        face_done;
    logic        job_done;
    logic [2:0]  dir;
    logic [7:0]  ext_w;
    logic [7:0]  ext_h;
    vfq_corner_t offs;

    always_comb
    begin
        dir       = cur_reg.cube ? face_reg : cur_reg.dir;
        ext_w     = cur_reg.cube ? 8'd1 : cur_reg.w;
        ext_h     = cur_reg.cube ? 8'd1 : cur_reg.h;
        offs      = corner_offsets(dir, emit_corner(k_reg));
        face_done = (k_reg == LAST_VERT);
        job_done  = active_reg && face_done && (!cur_reg.cube || face_reg == DIR_BACK);
        pop       = qstat.valid && (!active_reg || job_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            face_reg   <= DIR_TOP;
            k_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (pop)
            begin
                active_reg <= 1'b1;
                face_reg   <= DIR_TOP;
                k_reg      <= '0;
            end
            else if (job_done)
            begin
                active_reg <= 1'b0;
            end
            else if (active_reg)
            begin
                if (face_done)
                begin
                    k_reg    <= '0;
                    face_reg <= face_reg + 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        x_reg        <= add_off(cur_reg.pos_x, offs.x, ext_w, ext_h);
        y_reg        <= add_off(cur_reg.pos_y, offs.y, ext_w, ext_h);
        z_reg        <= add_off(cur_reg.pos_z, offs.z, ext_w, ext_h);
        voxel_reg    <= cur_reg.voxel;
        face_out_reg <= dir;
        last_reg     <= job_done;
    end

    assign vert_strobe = strobe_reg;
    assign vert_x      = x_reg;
    assign vert_y      = y_reg;
    assign vert_z      = z_reg;
    assign vert_voxel  = voxel_reg;
    assign vert_face   = face_out_reg;
    assign last_vertex = last_reg;

endmodule

### sv/voxel_face_quad_emitter.sv
// Top level of the voxel face quad emitter: front end, request queue and vertex back end.
//
// A request is taken on a rising edge with start high and busy low. A sized face
// (opcode 0) yields six vertices, a unit cube (opcode 1) yields 36, one vertex per
// cycle on vert_* marked by vert_strobe, with last_vertex on the final one; the
// receiver must take every vertex as it appears. A sized face with direction six
// or seven yields nothing. Throughput is set by the vertex back end, with face
// requests sustained back to back. A one-entry input stage and a two-entry queue
// absorb up to three requests ahead of the one being emitted; busy rises when
// they are all held. When the block is idle, a request passes the input stage,
// the queue and the back end's job register before its first vertex is registered.
module voxel_face_quad_emitter
    import vfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       opcode,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] pos_z,
    input  logic [2:0] direction,
    input  logic [7:0] voxel_id,
    input  logic [7:0] width,
    input  logic [7:0] height,
    output logic       vert_strobe,
    output logic [7:0] vert_x,
    output logic [7:0] vert_y,
    output logic [7:0] vert_z,
    output logic [7:0] vert_voxel,
    output logic [2:0] vert_face,
    output logic       last_vertex
);

    logic       push;
    logic       pop;
    vfq_item_t  push_item;
    vfq_item_t  head;
    vfq_qstat_t qstat;

    vfq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .direction (direction),
        .voxel_id  (voxel_id),
        .width     (width),
        .height    (height),
        .qstat     (qstat),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    vfq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    vfq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .vert_strobe (vert_strobe),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .vert_voxel  (vert_voxel),
        .vert_face   (vert_face),
        .last_vertex (last_vertex)
    );

`ifndef ASSERT_OFF
    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !qstat.valid))
        else $error("queue read while empty");

    // emitted vertices always carry a real face code
    a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
        vert_strobe |-> (vert_face < NUM_DIRS))
        else $error("vertex with bad face code");

    // after the closing vertex, the stream goes on only if the next job was
    // popped in the cycle that produced that closing vertex
    a_last_on_back_or_face: assert property (@(posedge clk) disable iff (!rst_n)
        (vert_strobe && last_vertex) |=> (!vert_strobe || $past(pop, 2)))
        else $error("vertex stream continued past end of run without a new job");
`endif

endmodule

### dv/tb_voxel_face_quad_emitter.sv
// Self-checking testbench for the voxel face quad emitter: directed table, then random requests.
`timescale 1ns / 1ps

module tb_voxel_face_quad_emitter;
    import vfq_pkg::*;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic [7:0] voxel;
        logic [2:0] face;
        logic       last;
    } vert_t;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        CHK_MODEL,  // from the predictor
        CHK_NONE,   // no vertices at all
        CHK_POINT   // degenerate quad, six copies of one point
    } row_chk_t;

    typedef struct packed {
        vfq_item_t  req;
        row_chk_t   chk;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] pz;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       opcode = OP_FACE;
    logic [7:0] pos_x = 8'd0;
    logic [7:0] pos_y = 8'd0;
    logic [7:0] pos_z = 8'd0;
    logic [2:0] direction = DIR_TOP;
    logic [7:0] voxel_id = 8'd0;
    logic [7:0] width = 8'd0;
    logic [7:0] height = 8'd0;
    logic       busy;
    logic       vert_strobe;
    logic [7:0] vert_x;
    logic [7:0] vert_y;
    logic [7:0] vert_z;
    logic [7:0] vert_voxel;
    logic [2:0] vert_face;
    logic       last_vertex;

    vert_t     expected_verts[$];
    stim_row_t stim_rows[$];
    int        mismatch_count = 0;
    int        verts_checked = 0;
    int        requests_sent = 0;
    int        cubes_sent = 0;
    int        dropped_sent = 0;

    voxel_face_quad_emitter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .direction   (direction),
        .voxel_id    (voxel_id),
        .width       (width),
        .height      (height),
        .vert_strobe (vert_strobe),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .vert_voxel  (vert_voxel),
        .vert_face   (vert_face),
        .last_vertex (last_vertex)
    );

    always #5 clk = ~clk;

    task automatic push_vert(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                             input logic [7:0] vox, input logic [2:0] face,
                             input logic last);
        vert_t v;
        v = {x, y, z, vox, face, last};
        expected_verts = {expected_verts, v};
    endtask

    // four corners of one face, emitted as triangles c0 c1 c2 / c2 c3 c0
    task automatic predict_face(input logic [2:0] dir, input logic [7:0] px,
                                input logic [7:0] py, input logic [7:0] pz,
                                input logic [7:0] vox, input logic [7:0] w,
                                input logic [7:0] h, input logic last_face);
        logic [7:0] cx [4];
        logic [7:0] cy [4];
        logic [7:0] cz [4];
        logic [7:0] xo, xw, xh, yo, yw, yh, zo, zw, zh;
        int c;
        xo = px + 8'd1;
        xw = px + w;
        xh = px + h;
        yo = py + 8'd1;
        yw = py + w;
        yh = py + h;
        zo = pz + 8'd1;
        zw = pz + w;
        zh = pz + h;
        case (dir)
            DIR_TOP:
            begin
                cx = '{px, px, xh, xh};
                cy = '{yo, yo, yo, yo};
                cz = '{pz, zw, zw, pz};
            end
            DIR_BOTTOM:
            begin
                cx = '{xh, xh, px, px};
                cy = '{py, py, py, py};
                cz = '{pz, zw, zw, pz};
            end
            DIR_RIGHT:
            begin
                cx = '{xo, xo, xo, xo};
                cy = '{yw, py, py, yw};
                cz = '{zh, zh, pz, pz};
            end
            DIR_LEFT:
            begin
                cx = '{px, px, px, px};
                cy = '{yw, py, py, yw};
                cz = '{pz, pz, zh, zh};
            end
            DIR_FRONT:
            begin
                cx = '{px, px, xw, xw};
                cy = '{yh, py, py, yh};
                cz = '{zo, zo, zo, zo};
            end
            DIR_BACK:
            begin
                cx = '{xw, xw, px, px};
                cy = '{yh, py, py, yh};
                cz = '{pz, pz, pz, pz};
            end
            default:
            begin
                return;
            end
        endcase
        for (int k = 0; k < 6; k++)
        begin
            c = (k == 5) ? 0 : ((k >= 3) ? k - 1 : k);
            push_vert(cx[c], cy[c], cz[c], vox, dir, last_face && (k == 5));
        end
    endtask

    task automatic predict_quad_vertices(input vfq_item_t req);
        if (req.cube == OP_CUBE)
        begin
            for (int f = 0; f < NUM_DIRS; f++)
                predict_face(f[2:0], req.pos_x, req.pos_y, req.pos_z, req.voxel,
                             8'd1, 8'd1, f == NUM_DIRS - 1);
        end
        else if (req.dir < NUM_DIRS)
        begin
            predict_face(req.dir, req.pos_x, req.pos_y, req.pos_z, req.voxel,
                         req.w, req.h, 1'b1);
        end
    endtask

    task automatic add_row(input logic op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] z, input logic [2:0] dir,
                           input logic [7:0] vox, input logic [7:0] w,
                           input logic [7:0] h, input row_chk_t chk,
                           input logic [7:0] ex, input logic [7:0] ey,
                           input logic [7:0] ez);
        stim_row_t r;
        r.req = {op, x, y, z, dir, vox, w, h};
        r.chk = chk;
        r.px = ex;
        r.py = ey;
        r.pz = ez;
        stim_rows = {stim_rows, r};
    endtask

    function automatic logic [7:0] pick_extent();
        logic [7:0] e;
        case ($urandom_range(7))
            0: e = 8'd0;
            1: e = 8'd255;
            2: e = 8'd1;
            default: e = 8'($urandom);
        endcase
        return e;
    endfunction

    function automatic vfq_item_t random_request();
        vfq_item_t r;
        r.cube = ($urandom_range(99) < 15) ? OP_CUBE : OP_FACE;
        r.pos_x = 8'($urandom);
        r.pos_y = 8'($urandom);
        r.pos_z = 8'($urandom);
        r.voxel = 8'($urandom);
        r.w = pick_extent();
        r.h = pick_extent();
        if (r.cube == OP_CUBE || $urandom_range(99) < 8)
            r.dir = 3'($urandom);
        else
            r.dir = 3'($urandom_range(NUM_DIRS - 1));
        return r;
    endfunction

    // returns in the time step of the transfer
    task automatic issue_request(input vfq_item_t req, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        opcode <= req.cube;
        pos_x <= req.pos_x;
        pos_y <= req.pos_y;
        pos_z <= req.pos_z;
        direction <= req.dir;
        voxel_id <= req.voxel;
        width <= req.w;
        height <= req.h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        if (req.cube == OP_CUBE)
            cubes_sent++;
        else if (req.dir >= NUM_DIRS)
            dropped_sent++;
    endtask

    always @(posedge clk)
    begin
        vert_t got;
        vert_t want;
        if (rst_n && vert_strobe)
        begin
            got = {vert_x, vert_y, vert_z, vert_voxel, vert_face, last_vertex};
            if (expected_verts.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: exp no vertex, act x=%0d y=%0d z=%0d voxel=%0d face=%0d last=%0b",
                         $time, got.x, got.y, got.z, got.voxel, got.face, got.last);
            end
            else
            begin
                want = expected_verts.pop_front();
                verts_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    $display("%0t: vertex mismatch exp x=%0d y=%0d z=%0d voxel=%0d face=%0d last=%0b",
                             $time, want.x, want.y, want.z, want.voxel, want.face,
                             want.last);
                    $display("%0t:                 act x=%0d y=%0d z=%0d voxel=%0d face=%0d last=%0b",
                             $time, got.x, got.y, got.z, got.voxel, got.face,
                             got.last);
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        vfq_item_t req;
        int idle_pct;
        int counted;

        // degenerate quads collapse to one point; wraps at 255
        add_row(OP_FACE, 8'd0, 8'd255, 8'd0, DIR_TOP, 8'd0, 8'd0, 8'd0,
                CHK_POINT, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd255, 8'd255, 8'd255, DIR_BOTTOM, 8'd255, 8'd0, 8'd0,
                CHK_POINT, 8'd255, 8'd255, 8'd255);
        add_row(OP_FACE, 8'd255, 8'd0, 8'd0, DIR_RIGHT, 8'd1, 8'd0, 8'd0,
                CHK_POINT, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd128, 8'd64, 8'd32, DIR_LEFT, 8'd170, 8'd0, 8'd0,
                CHK_POINT, 8'd128, 8'd64, 8'd32);
        add_row(OP_FACE, 8'd0, 8'd0, 8'd255, DIR_FRONT, 8'd85, 8'd0, 8'd0,
                CHK_POINT, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd255, 8'd255, 8'd255, DIR_BACK, 8'd255, 8'd0, 8'd0,
                CHK_POINT, 8'd255, 8'd255, 8'd255);
        // invalid directions produce nothing
        add_row(OP_FACE, 8'd12, 8'd34, 8'd56, 3'd6, 8'd255, 8'd255, 8'd255,
                CHK_NONE, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd255, 8'd255, 8'd255, 3'd7, 8'd255, 8'd255, 8'd255,
                CHK_NONE, 8'd0, 8'd0, 8'd0);
        // full extents from the top corner, every direction
        for (int d = 0; d < NUM_DIRS; d++)
            add_row(OP_FACE, 8'd255, 8'd255, 8'd255, d[2:0], 8'd255, 8'd255, 8'd255,
                    CHK_MODEL, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd10, 8'd20, 8'd30, DIR_RIGHT, 8'd7, 8'd255, 8'd0,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd10, 8'd20, 8'd30, DIR_FRONT, 8'd7, 8'd0, 8'd255,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd100, 8'd100, 8'd100, DIR_TOP, 8'd42, 8'd1, 8'd1,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);
        add_row(OP_FACE, 8'd0, 8'd0, 8'd0, DIR_BACK, 8'd0, 8'd3, 8'd200,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);
        // cube ignores direction and extents
        add_row(OP_CUBE, 8'd0, 8'd0, 8'd0, DIR_TOP, 8'd0, 8'd0, 8'd0,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);
        add_row(OP_CUBE, 8'd255, 8'd255, 8'd255, 3'd7, 8'd255, 8'd0, 8'd255,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);
        add_row(OP_CUBE, 8'd127, 8'd128, 8'd254, 3'd6, 8'd99, 8'd255, 8'd255,
                CHK_MODEL, 8'd0, 8'd0, 8'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            issue_request(row.req, 0);
            case (row.chk)
                CHK_POINT:
                begin
                    for (int k = 0; k < 6; k++)
                        push_vert(row.px, row.py, row.pz, row.req.voxel, row.req.dir,
                                  k == 5);
                end
                CHK_MODEL:
                begin
                    predict_quad_vertices(row.req);
                end
                default:
                begin
                end
            endcase
        end

        // random phases: back to back, sparse sender, light gaps
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 1) ? 63 : ((phase == 2) ? 12 : 0);
            counted = 0;
            while (counted < 72)
            begin
                req = random_request();
                issue_request(req, idle_pct);
                predict_quad_vertices(req);
                if (req.cube == OP_CUBE || req.dir < NUM_DIRS)
                    counted++;
            end
        end
        start <= 1'b0;

        while (expected_verts.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d requests (%0d cubes, %0d with invalid direction).",
                 requests_sent, cubes_sent, dropped_sent);
        $display("Checked %0d vertices, %0d mismatches.", verts_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout with %0d vertices still expected.", expected_verts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
